@@ rtl/assert_macros.svh @@
// Assertion helpers for the timer bank checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masks the check.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer bank check failed");

// Next-cycle implication, reset masks the check.
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer bank check failed");

`endif

@@ rtl/tbrd_pkg.sv @@
package tbrd_pkg;

  // stream widths
  localparam int S_DATA_W = 104;
  localparam int M_DATA_W = 8;

  // input beat layout (s_tdata)
  localparam int SLOT_LO  = 0;
  localparam int DUR_LO   = 4;
  localparam int DELAY_LO = 36;
  localparam int REP_BIT  = 67;
  localparam int ELAP_LO  = 68;

  // commands (s_tuser)
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_CREATE = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_QUERY  = 2'd3;

  // result kinds (m_tuser)
  localparam logic [1:0] KIND_REPLY = 2'd0;
  localparam logic [1:0] KIND_FIRE  = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  // reply status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NEG_DUR   = 2'd1;
  localparam logic [1:0] ST_IN_USE    = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [15:0] DILATION_RESET = 16'd256;
  localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic               sub;
    logic signed [32:0] a;
    logic signed [32:0] b;
  } alu_req_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               pos;
  } alu_res_t;

  typedef struct packed {
    logic [30:0]        period;
    logic signed [31:0] tval;
    logic               rep;
  } slot_rec_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] status;
    logic [3:0] slot;
    logic       present;
    logic       last;
  } result_t;

endpackage

@@ rtl/timer_bank_with_repeat_and_delay_core.sv @@
// Timer bank: TIMER_SLOTS slots, each with a period, a repeat flag and a
// running time in signed Q16.16 seconds.
// Input stream (s_*): one beat is one command, selected by s_tuser
// (tick, create, remove, query). Create/remove/query give one reply beat;
// a tick gives one fire beat per firing, slots in ascending order, then a
// tick-finished beat with m_tlast set. Every command's last beat has tlast.
// Config: cfg_we writes the Q8.8 dilation factor (reset 1.0); write it only
// while the bank is idle.
// A command reply passes through the command state into the result register.
// A tick walks the slot store one slot at a time through the single
// add/subtract unit and the registered store read.
// One command is in flight at a time: s_tready is high only when idle.
// Stall: the result register holds its beat while m_tready is low and the
// walk waits on it; nothing is dropped.
// Reset: all slots inactive, dilation back to 1.0, output empty. The slot
// store itself is not cleared; a slot is only read while it is active.
module timer_bank_with_repeat_and_delay_core #(
  parameter int TIMER_SLOTS        = 16,
  parameter int MAX_FIRES_PER_TICK = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  // config: dilation, unsigned Q8.8
  input  logic                          cfg_we,
  input  logic [15:0]                   cfg_wdata,
  // command stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [3:0] slot, [35:4] duration, [66:36] delay, [67] repeat_req,
  // [98:68] elapsed, [103:99] zero
  input  logic [tbrd_pkg::S_DATA_W-1:0] s_tdata,
  input  logic [1:0]                    s_tuser,   // [1:0] cmd
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [1:0] status, [5:2] fired_slot, [6] present, [7] zero
  output logic [tbrd_pkg::M_DATA_W-1:0] m_tdata,
  output logic [1:0]                    m_tuser,   // [1:0] kind
  output logic                          m_tlast    // last
);

  localparam int SLOT_W = $clog2(TIMER_SLOTS);

  logic [15:0]         dilation;
  tbrd_pkg::alu_req_t  alu_req;
  tbrd_pkg::alu_res_t  alu_res;
  logic                mem_we;
  logic [SLOT_W-1:0]   mem_waddr;
  logic [SLOT_W-1:0]   mem_raddr;
  tbrd_pkg::slot_rec_t mem_wdata;
  tbrd_pkg::slot_rec_t mem_rdata;

  // dilation register
  always_ff @(posedge clk) begin
    if (rst) begin
      dilation <= tbrd_pkg::DILATION_RESET;
    end else if (cfg_we) begin
      dilation <= cfg_wdata;
    end
  end

  tbrd_ctrl #(
    .TIMER_SLOTS        (TIMER_SLOTS),
    .MAX_FIRES_PER_TICK (MAX_FIRES_PER_TICK)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .dilation  (dilation),
    .alu_req   (alu_req),
    .alu_res   (alu_res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // one add/subtract unit shared by delay negate, time advance and fire test
  tbrd_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  tbrd_mem #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

@@ rtl/tbrd_alu.sv @@
// Shared add/subtract unit: saturating add, plain subtract, sign test.
module tbrd_alu (
  input  tbrd_pkg::alu_req_t req,
  output tbrd_pkg::alu_res_t res
);

  localparam logic signed [33:0] SAT_HI = 34'sh0_7FFF_FFFF;

  logic signed [33:0] a_ext;
  logic signed [33:0] b_ext;
  logic signed [33:0] full;

  always_comb begin
    a_ext = {req.a[32], req.a};
    b_ext = {req.b[32], req.b};
    full  = req.sub ? (a_ext - b_ext) : (a_ext + b_ext);
    res.pos = !full[33] && (full != 34'sd0);
    if (!req.sub && (full > SAT_HI)) begin
      res.value = tbrd_pkg::Q_MAX;
    end else begin
      res.value = full[31:0];
    end
  end

endmodule

@@ rtl/tbrd_mem.sv @@
// Per-slot period / time / repeat store, one write and one registered read.
module tbrd_mem #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(TIMER_SLOTS)-1:0] waddr,
  input  tbrd_pkg::slot_rec_t            wdata,
  input  logic [$clog2(TIMER_SLOTS)-1:0] raddr,
  output tbrd_pkg::slot_rec_t            rdata
);

  tbrd_pkg::slot_rec_t store [TIMER_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
    rdata <= store[raddr];
  end

endmodule

@@ rtl/tbrd_ctrl.sv @@
// Sequencer: command decode, slot walk on ticks, active bits, result register.
module tbrd_ctrl #(
  parameter int TIMER_SLOTS        = 16,
  parameter int MAX_FIRES_PER_TICK = 3
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [tbrd_pkg::S_DATA_W-1:0]   s_tdata,
  input  logic [1:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [tbrd_pkg::M_DATA_W-1:0]   m_tdata,
  output logic [1:0]                      m_tuser,
  output logic                            m_tlast,
  input  logic [15:0]                     dilation,
  output tbrd_pkg::alu_req_t              alu_req,
  input  tbrd_pkg::alu_res_t              alu_res,
  output logic                            mem_we,
  output logic [$clog2(TIMER_SLOTS)-1:0]  mem_waddr,
  output tbrd_pkg::slot_rec_t             mem_wdata,
  output logic [$clog2(TIMER_SLOTS)-1:0]  mem_raddr,
  input  tbrd_pkg::slot_rec_t             mem_rdata
);

  localparam int SLOT_W = $clog2(TIMER_SLOTS);
  localparam int FIRE_W = $clog2(MAX_FIRES_PER_TICK + 1);
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TIMER_SLOTS - 1);
  localparam logic [FIRE_W-1:0] FIRE_CAP = FIRE_W'(MAX_FIRES_PER_TICK);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CMD   = 3'd1;
  localparam logic [2:0] S_SCALE = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_ADD   = 3'd4;
  localparam logic [2:0] S_CMP   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]             state;
  logic [TIMER_SLOTS-1:0] active;
  logic [SLOT_W-1:0]      idx;
  logic [FIRE_W-1:0]      fires;

  // captured command beat
  logic [1:0]         cmd;
  logic [3:0]         slot_q;
  logic signed [31:0] dur;
  logic [30:0]        delay;
  logic               rep;
  logic [46:0]        prod;
  logic [30:0]        dil;
  logic signed [31:0] t;

  tbrd_pkg::result_t  out_q;
  tbrd_pkg::result_t  emit_val;
  logic               emit;
  logic               out_free;

  logic [SLOT_W+3:0]  slot_ext;
  logic [SLOT_W+3:0]  idx_ext;
  logic [SLOT_W-1:0]  cmd_idx;
  logic               in_bank;
  logic               act;
  logic [1:0]         cmd_status;
  logic               cmd_set;
  logic               cmd_clr;
  logic               fire;
  logic               last_slot;

  assign s_tready  = (state == S_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign m_tdata   = {1'b0, out_q.present, out_q.slot, out_q.status};
  assign m_tuser   = out_q.kind;
  assign m_tlast   = out_q.last;

  assign slot_ext  = {{SLOT_W{1'b0}}, slot_q};
  assign idx_ext   = {4'b0, idx};
  assign cmd_idx   = slot_ext[SLOT_W-1:0];
  assign in_bank   = slot_ext < (SLOT_W + 4)'(TIMER_SLOTS);
  assign act       = in_bank && active[cmd_idx];
  assign fire      = alu_res.pos && (fires != FIRE_CAP);
  assign last_slot = (idx == LAST_IDX);

  // command reply decode
  always_comb begin
    cmd_status = tbrd_pkg::ST_NOT_FOUND;
    cmd_set    = 1'b0;
    cmd_clr    = 1'b0;
    unique case (cmd)
      tbrd_pkg::CMD_CREATE: begin
        if (dur[31]) begin
          cmd_status = tbrd_pkg::ST_NEG_DUR;
        end else if (!in_bank) begin
          cmd_status = tbrd_pkg::ST_NOT_FOUND;
        end else if (act) begin
          cmd_status = tbrd_pkg::ST_IN_USE;
        end else begin
          cmd_status = tbrd_pkg::ST_OK;
          cmd_set    = 1'b1;
        end
      end
      tbrd_pkg::CMD_REMOVE: begin
        cmd_status = act ? tbrd_pkg::ST_OK : tbrd_pkg::ST_NOT_FOUND;
        cmd_clr    = act;
      end
      tbrd_pkg::CMD_QUERY: begin
        cmd_status = act ? tbrd_pkg::ST_OK : tbrd_pkg::ST_NOT_FOUND;
      end
      default: begin
        cmd_status = tbrd_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  // operand select for the shared unit
  always_comb begin
    alu_req = '0;
    unique case (state)
      S_CMD: begin
        alu_req.sub = 1'b1;
        alu_req.b   = {2'b0, delay};
      end
      S_ADD: begin
        alu_req.a = {mem_rdata.tval[31], mem_rdata.tval};
        alu_req.b = {2'b0, dil};
      end
      S_CMP: begin
        alu_req.sub = 1'b1;
        alu_req.a   = {t[31], t};
        alu_req.b   = {2'b0, mem_rdata.period};
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  // store write: create loads a slot, a walk writes back the leftover time
  always_comb begin
    mem_raddr = idx;
    if (state == S_CMD) begin
      mem_we    = out_free && cmd_set;
      mem_waddr = cmd_idx;
      mem_wdata = '{period: dur[30:0], tval: alu_res.value, rep: rep};
    end else begin
      mem_we    = (state == S_CMP) && !fire;
      mem_waddr = idx;
      mem_wdata = '{period: mem_rdata.period, tval: t, rep: mem_rdata.rep};
    end
  end

  // result to load into the output register
  always_comb begin
    emit     = 1'b0;
    emit_val = '{kind: tbrd_pkg::KIND_DONE, status: tbrd_pkg::ST_OK, slot: 4'd0,
                 present: 1'b0, last: 1'b1};
    unique case (state)
      S_CMD: begin
        emit     = out_free;
        emit_val = '{kind: tbrd_pkg::KIND_REPLY, status: cmd_status, slot: slot_q,
                     present: (cmd == tbrd_pkg::CMD_QUERY) && act, last: 1'b1};
      end
      S_CMP: begin
        emit     = out_free && fire;
        emit_val = '{kind: tbrd_pkg::KIND_FIRE, status: tbrd_pkg::ST_OK,
                     slot: idx_ext[3:0], present: 1'b0, last: 1'b0};
      end
      S_DONE: begin
        emit = out_free;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (emit) begin
      out_q <= emit_val;
    end
  end

  // payload capture and walk datapath
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd    <= s_tuser;
      slot_q <= s_tdata[tbrd_pkg::SLOT_LO +: 4];
      dur    <= s_tdata[tbrd_pkg::DUR_LO +: 32];
      delay  <= s_tdata[tbrd_pkg::DELAY_LO +: 31];
      rep    <= s_tdata[tbrd_pkg::REP_BIT];
      prod   <= 47'(s_tdata[tbrd_pkg::ELAP_LO +: 31]) * 47'(dilation);
    end
    if (state == S_SCALE) begin
      dil <= (prod[46:39] != 8'd0) ? 31'h7FFF_FFFF : prod[38:8];
    end
    if (state == S_ADD) begin
      t <= alu_res.value;
    end else if ((state == S_CMP) && emit) begin
      t <= alu_res.value;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      active <= '0;
      idx    <= '0;
      fires  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= (s_tuser == tbrd_pkg::CMD_TICK) ? S_SCALE : S_CMD;
          end
        end
        S_CMD: begin
          if (out_free) begin
            if (cmd_set) begin
              active[cmd_idx] <= 1'b1;
            end
            if (cmd_clr) begin
              active[cmd_idx] <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        S_SCALE: begin
          idx   <= '0;
          state <= S_RD;
        end
        S_RD: begin
          if (active[idx]) begin
            state <= S_ADD;
          end else if (last_slot) begin
            state <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_ADD: begin
          fires <= '0;
          state <= S_CMP;
        end
        S_CMP: begin
          if (!fire || (emit && !mem_rdata.rep)) begin
            // leftover written back, or one-shot freed: next slot
            if (fire) begin
              active[idx] <= 1'b0;
            end
            if (last_slot) begin
              state <= S_DONE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_RD;
            end
          end else if (emit) begin
            fires <= fires + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/tbrd_chk.sv @@
`include "assert_macros.svh"

module tbrd_chk (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [1:0] m_tuser,
  input logic       m_tlast
);

  // stalled result beat holds
  `ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

  // fire beats never close a command and carry success only
  `ASSERT_IMP(a_fire_fmt, clk, rst, m_tvalid && (m_tuser == tbrd_pkg::KIND_FIRE), !m_tlast && (m_tdata[1:0] == tbrd_pkg::ST_OK) && !m_tdata[6])

  // tick-finished beat closes the tick with empty fields
  `ASSERT_IMP(a_done_fmt, clk, rst, m_tvalid && (m_tuser == tbrd_pkg::KIND_DONE), m_tlast && (m_tdata == 8'd0))

  // replies are single beats; present only on success
  `ASSERT_IMP(a_reply_fmt, clk, rst, m_tvalid && (m_tuser == tbrd_pkg::KIND_REPLY), m_tlast && (!m_tdata[6] || (m_tdata[1:0] == tbrd_pkg::ST_OK)))

endmodule

bind timer_bank_with_repeat_and_delay_core tbrd_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

@@ tb/tb.sv @@
module tb;

  localparam int NUM_SLOTS     = 16;
  localparam int FIRE_CAP      = 3;
  localparam int CYCLE_LIMIT   = 5_000_000;
  localparam int IDLE_PAUSE    = 12;   // settle before a dilation write
  localparam int SETTLE_CYCLES = 120;  // longest tick walk plus margin
  localparam longint Q_LIMIT   = 64'sh7FFF_FFFF;

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [15:0]                   cfg_wdata;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [tbrd_pkg::S_DATA_W-1:0] s_tdata;
  logic [1:0]                    s_tuser;
  logic                          m_tvalid;
  logic                          m_tready;
  logic [tbrd_pkg::M_DATA_W-1:0] m_tdata;
  logic [1:0]                    m_tuser;
  logic                          m_tlast;

  timer_bank_with_repeat_and_delay_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // Timer bank mirror, updated at each accepted command beat
  bit                 tm_active [NUM_SLOTS];
  logic [30:0]        tm_period [NUM_SLOTS];
  logic signed [31:0] tm_time   [NUM_SLOTS];
  bit                 tm_repeat [NUM_SLOTS];
  logic [15:0]        tm_dilation;

  tbrd_pkg::result_t due_beats[$];   // result beats still owed by the bank
  int unsigned fail_count = 0;
  int unsigned cycles_run = 0;
  bit          tx_idle;        // random gaps on the command side
  bit          rx_idle;        // random stalls on the result side

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Expected beats for one command; tm_* hold the bank state
  task automatic step_timer_bank(input logic [1:0] cmd,
                                 input logic [tbrd_pkg::S_DATA_W-1:0] beat);
    logic [3:0]  slot;
    logic [31:0] dur;
    logic [30:0] dly;
    logic        rep;
    logic [30:0] elap;
    longint      scaled;
    longint      t;
    longint      period;
    int          fires;
    tbrd_pkg::result_t r;
    slot = beat[tbrd_pkg::SLOT_LO +: 4];
    dur  = beat[tbrd_pkg::DUR_LO +: 32];
    dly  = beat[tbrd_pkg::DELAY_LO +: 31];
    rep  = beat[tbrd_pkg::REP_BIT];
    elap = beat[tbrd_pkg::ELAP_LO +: 31];
    r = '0;
    r.kind = tbrd_pkg::KIND_REPLY;
    r.slot = slot;
    r.last = 1'b1;
    case (cmd)
      tbrd_pkg::CMD_TICK: begin
        // Q16.16 * Q8.8 >> 8, truncated, then clamped to the Q16.16 max
        scaled = (longint'(elap) * longint'(tm_dilation)) >>> 8;
        if (scaled > Q_LIMIT) scaled = Q_LIMIT;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (tm_active[i]) begin
            t = longint'(tm_time[i]) + scaled;
            if (t > Q_LIMIT) t = Q_LIMIT;
            period = longint'(tm_period[i]);
            fires = 0;
            while (t > period && fires < FIRE_CAP) begin
              r.kind    = tbrd_pkg::KIND_FIRE;
              r.status  = tbrd_pkg::ST_OK;
              r.slot    = 4'(i);
              r.present = 1'b0;
              r.last    = 1'b0;
              due_beats.push_back(r);
              t -= period;
              fires++;
              // one-shot: freed on its first fire
              if (!tm_repeat[i]) begin
                tm_active[i] = 1'b0;
                break;
              end
            end
            tm_time[i] = t[31:0];
          end
        end
        r.kind    = tbrd_pkg::KIND_DONE;
        r.status  = tbrd_pkg::ST_OK;
        r.slot    = '0;
        r.present = 1'b0;
        r.last    = 1'b1;
      end
      tbrd_pkg::CMD_CREATE: begin
        // sign check wins over the in-use check
        if (dur[31]) begin
          r.status = tbrd_pkg::ST_NEG_DUR;
        end else if (tm_active[slot]) begin
          r.status = tbrd_pkg::ST_IN_USE;
        end else begin
          t = -longint'(dly);
          tm_active[slot] = 1'b1;
          tm_period[slot] = dur[30:0];
          tm_repeat[slot] = rep;
          tm_time[slot]   = t[31:0];
          r.status = tbrd_pkg::ST_OK;
        end
      end
      tbrd_pkg::CMD_REMOVE: begin
        if (tm_active[slot]) begin
          tm_active[slot] = 1'b0;
          r.status = tbrd_pkg::ST_OK;
        end else begin
          r.status = tbrd_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        r.present = tm_active[slot];
        r.status  = tm_active[slot] ? tbrd_pkg::ST_OK : tbrd_pkg::ST_NOT_FOUND;
      end
    endcase
    due_beats.push_back(r);
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Monitor: check the result beat of this edge, then register config and
  // command beats. Results trail their command through the sequencer and the
  // result register, so the order inside this block is safe.
  tbrd_pkg::result_t want;
  always @(posedge clk) begin
    if (rst) begin
      foreach (tm_active[i]) tm_active[i] = 1'b0;
      tm_dilation = tbrd_pkg::DILATION_RESET;
      due_beats.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (due_beats.size() == 0) begin
          $error("result beat with nothing pending: kind %0d slot %0d", m_tuser, m_tdata[5:2]);
          fail_count++;
        end else begin
          want = due_beats.pop_front();
          compare_field("kind", want.kind, m_tuser);
          compare_field("status", want.status, m_tdata[1:0]);
          compare_field("fired_slot", want.slot, m_tdata[5:2]);
          compare_field("present", want.present, m_tdata[6]);
          compare_field("last", want.last, m_tlast);
        end
      end
      if (cfg_we) tm_dilation = cfg_wdata;
      if (s_tvalid && s_tready) step_timer_bank(s_tuser, s_tdata);
    end
  end

  // Result side back-pressure
  initial begin
    int unsigned hold;
    hold = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        m_tready <= 1'b0;
        hold--;
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        hold = gap_len();
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // One command beat; returns right after the edge that took it
  task automatic send_beat(input logic [1:0] cmd, input logic [3:0] slot,
                           input logic [31:0] dur, input logic [30:0] dly,
                           input logic rep, input logic [30:0] elap);
    logic [tbrd_pkg::S_DATA_W-1:0] beat;
    int unsigned                   gap;
    beat = '0;
    beat[tbrd_pkg::SLOT_LO +: 4]   = slot;
    beat[tbrd_pkg::DUR_LO +: 32]   = dur;
    beat[tbrd_pkg::DELAY_LO +: 31] = dly;
    beat[tbrd_pkg::REP_BIT]        = rep;
    beat[tbrd_pkg::ELAP_LO +: 31]  = elap;
    gap = tx_idle ? gap_len() : 0;
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= beat;
    do @(posedge clk); while (!s_tready);
  endtask

  // Unused fields carry random noise
  task automatic do_tick(input logic [30:0] elap);
    send_beat(tbrd_pkg::CMD_TICK, 4'($urandom()), $urandom(), 31'($urandom()),
              1'($urandom()), elap);
  endtask

  task automatic do_create(input logic [3:0] slot, input logic [31:0] dur,
                           input logic [30:0] dly, input logic rep);
    send_beat(tbrd_pkg::CMD_CREATE, slot, dur, dly, rep, 31'($urandom()));
  endtask

  task automatic do_remove(input logic [3:0] slot);
    send_beat(tbrd_pkg::CMD_REMOVE, slot, $urandom(), 31'($urandom()), 1'($urandom()),
              31'($urandom()));
  endtask

  task automatic do_query(input logic [3:0] slot);
    send_beat(tbrd_pkg::CMD_QUERY, slot, $urandom(), 31'($urandom()), 1'($urandom()),
              31'($urandom()));
  endtask

  task automatic wait_idle(input int unsigned pause);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
    repeat (pause) @(posedge clk);
  endtask

  // Dilation is written only with the bank idle
  task automatic set_dilation(input logic [15:0] value);
    wait_idle(IDLE_PAUSE);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic test_command_replies();
    do_query(4'd3);                                   // empty slot
    do_remove(4'd3);                                  // nothing to remove
    do_create(4'd0, 32'h8000_0000, 31'd0, 1'b1);      // most negative period
    do_create(4'd0, 32'hFFFF_FFFF, 31'd0, 1'b1);      // -1 LSB
    do_create(4'd0, 32'h0001_0000, 31'd0, 1'b1);
    do_create(4'd0, 32'h0002_0000, 31'd5, 1'b0);      // slot busy
    do_query(4'd0);
    do_remove(4'd0);
    do_query(4'd0);
  endtask

  task automatic test_fire_and_free();
    do_create(4'd0, 32'h0001_0000, 31'd0, 1'b1);              // 1 s periodic
    do_create(4'd5, 32'h0000_0000, 31'd0, 1'b1);              // zero period
    do_create(4'd15, 32'h0000_8000, 31'h0001_0000, 1'b0);     // one-shot, 1 s delay
    do_create(4'd9, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);      // largest period, delay
    do_tick(31'd0);                // nothing crosses
    do_tick(31'h0003_8000);        // capped fires, one-shot freed
    do_tick(31'h7FFF_FFFF);        // running time clamps at max
    do_tick(31'h7FFF_FFFF);        // time equal to period: no fire
    do_query(4'd15);
    do_create(4'd15, 32'h0000_4000, 31'd0, 1'b1);
    do_remove(4'd5);
  endtask

  task automatic test_dilation_extremes();
    set_dilation(16'hFFFF);
    do_tick(31'h7FFF_FFFF);        // scaled value clamps
    do_tick(31'd1);
    set_dilation(16'h0000);
    do_tick(31'h7FFF_FFFF);        // no time added; leftover time still fires
    set_dilation(16'h0001);
    do_tick(31'h0000_0100);
  endtask

  // Phases of random commands, each under its own dilation
  task automatic test_random_traffic();
    int unsigned pick;
    int unsigned sel;
    logic [31:0] dur;
    logic [30:0] dly;
    logic [30:0] elap;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       set_dilation(tbrd_pkg::DILATION_RESET);
        1:       set_dilation(16'h0040);
        2:       set_dilation(16'h0300);
        3:       set_dilation(16'($urandom_range(1, 65535)));
        default: set_dilation(16'hFFFF);
      endcase
      // first phase runs back to back on both sides
      tx_idle = (phase != 0);
      rx_idle = (phase != 0);
      repeat (70) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          sel = $urandom_range(0, 9);
          if (sel == 0)      elap = '0;
          else if (sel < 3)  elap = 31'($urandom());
          else               elap = 31'($urandom_range(1, 32'h0004_0000));
          do_tick(elap);
        end else if (pick < 72) begin
          sel = $urandom_range(0, 9);
          if (sel == 0)      dur = {1'b1, 31'($urandom())};
          else if (sel == 1) dur = '0;
          else if (sel < 4)  dur = {1'b0, 31'($urandom())};
          else               dur = $urandom_range(1, 32'h0003_0000);
          sel = $urandom_range(0, 9);
          if (sel < 3)       dly = '0;
          else if (sel < 7)  dly = 31'($urandom_range(0, 32'h0003_0000));
          else               dly = 31'($urandom());
          do_create(4'($urandom()), dur, dly, 1'($urandom()));
        end else if (pick < 86) begin
          do_remove(4'($urandom()));
        end else begin
          do_query(4'($urandom()));
        end
      end
    end
  endtask

  initial begin
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("FAIL timer_bank_with_repeat_and_delay_core");
    $finish;
  end

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = tbrd_pkg::CMD_TICK;
    tx_idle   = 1'b0;
    rx_idle   = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_command_replies();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    test_fire_and_free();
    test_dilation_extremes();
    test_random_traffic();

    wait_idle(SETTLE_CYCLES);
    if (fail_count == 0) begin
      $display("PASS timer_bank_with_repeat_and_delay_core");
    end else begin
      $display("FAIL timer_bank_with_repeat_and_delay_core");
    end
    $finish;
  end

endmodule
